// ===== design/kvt_pkg.sv =====
package kvt_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_ERASE   = 2'd1,
    CMD_KEY_Q   = 2'd2,
    CMD_VALUE_Q = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_MOVE = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   entry_count;
  } result_t;

endpackage

// ===== design/kvt_in_if.sv =====
interface kvt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

// ===== design/kvt_out_if.sv =====
interface kvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== design/kvt_ram.sv =====
module kvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kvt_ctrl.sv =====
module kvt_ctrl
  import kvt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  kvt_in_if.sink                     in_ch,
  output logic                       res_valid,
  output result_t                    res,
  input  logic                       res_ready,
  output logic                       ram_we,
  output logic [$clog2(ENTRIES)-1:0] ram_waddr,
  output logic [KEY_W+VALUE_W-1:0]   ram_wdata,
  output logic [$clog2(ENTRIES)-1:0] ram_raddr,
  input  logic [KEY_W+VALUE_W-1:0]   ram_rdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t             state, state_next;
  cmd_t               op;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_ptr;
  logic               cmp_vld;
  logic [AW-1:0]      cmp_idx;
  logic [AW-1:0]      slot;
  status_t            status_q;

  logic               hit;
  logic               issue;
  logic               scan_end;
  logic               full;
  logic [CW-1:0]      last_wide;
  logic [AW-1:0]      last;
  logic [CW+COUNT_W-1:0] count_ext;

  assign full      = (count == CW'(ENTRIES));
  assign last_wide = count - 1'b1;
  assign last      = last_wide[AW-1:0];
  assign count_ext = {{COUNT_W{1'b0}}, count};

  always_comb begin
    if (op == CMD_VALUE_Q) begin
      hit = cmp_vld && (ram_rdata[VALUE_W-1:0] == value_q);
    end else begin
      hit = cmp_vld && (ram_rdata[KEY_W+VALUE_W-1:VALUE_W] == key_q);
    end
    issue    = !hit && (rd_ptr < count);
    scan_end = hit || (!cmp_vld && !(rd_ptr < count));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = (op == CMD_ERASE && hit) ? S_MOVE : S_DONE;
        end
      end
      S_MOVE: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    res_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = count[AW-1:0];
    ram_wdata   = {key_q, value_q};
    ram_raddr   = rd_ptr[AW-1:0];
    unique case (state)
      S_IDLE: in_ch.ready = 1'b1;
      S_SCAN: begin
        if (hit && op == CMD_ERASE) begin
          ram_raddr = last;
        end
        if (scan_end && !hit && op == CMD_INSERT && !full) begin
          ram_we = 1'b1;
        end
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = slot;
        ram_wdata = ram_rdata;
      end
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.status      = status_q;
  assign res.entry_count = count_ext[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cmp_vld <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          rd_ptr  <= '0;
          cmp_vld <= 1'b0;
        end
        S_SCAN: begin
          cmp_vld <= issue;
          if (issue) begin
            cmp_idx <= rd_ptr[AW-1:0];
            rd_ptr  <= rd_ptr + 1'b1;
          end
          if (scan_end) begin
            unique case (op)
              CMD_INSERT: begin
                if (hit) begin
                  status_q <= ST_DUP;
                end else if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  status_q <= ST_OK;
                  count    <= count + 1'b1;
                end
              end
              CMD_ERASE: begin
                status_q <= hit ? ST_OK : ST_MISS;
                slot     <= cmp_idx;
              end
              default: status_q <= hit ? ST_OK : ST_MISS;
            endcase
          end
        end
        S_MOVE: count <= last_wide;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      op      <= cmd_t'(in_ch.cmd);
      key_q   <= in_ch.key;
      value_q <= in_ch.value;
    end
  end

endmodule

// ===== design/keyed_value_table.sv =====
// The search walks the valid entries in order until a hit or the end of the table;
// an early hit ends it sooner, and an erase that hits adds a move step that copies
// the last entry into the freed slot.
// One operation runs at a time; a new one is taken only after the last result is
// handed on. The search reads the table RAM through its one read port, one slot per cycle.
// Reset clears the entry count and the control state; the table RAM is not cleared.
module keyed_value_table
  import kvt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst,
  kvt_in_if.sink     in_ch,
  kvt_out_if.source  out_ch
);

  localparam int AW = $clog2(ENTRIES);

  logic                     res_valid;
  logic                     res_ready;
  result_t                  res;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [KEY_W+VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [KEY_W+VALUE_W-1:0] ram_rdata;

  kvt_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  kvt_ram #(.WIDTH(KEY_W + VALUE_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // hold the result until the sink takes it
  assign res_ready = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_ch.status      <= res.status;
      out_ch.entry_count <= res.entry_count;
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed while output register full");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |-> !res_valid)
    else $error("input transfer while a result is pending");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.status == ST_FULL |->
      res.entry_count == COUNT_W'(ENTRIES))
    else $error("table full reported below capacity");

endmodule

// ===== tb/sv/tb_keyed_value_table.sv =====
`timescale 1ns / 1ps

module tb_keyed_value_table
  import kvt_pkg::*;
();

  localparam int ENTRIES    = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 40;
  localparam int LONG_HOLD  = 400;

  typedef struct {
    cmd_t         op;
    logic [31:0]  key;
    logic [31:0]  value;
    bit           drain_first;
  } table_op_t;

  logic clk;
  logic rst;

  kvt_in_if  in_ch ();
  kvt_out_if out_ch ();

  keyed_value_table #(.ENTRIES(ENTRIES)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  table_op_t   op_queue[$];
  result_t     due_results[$];

  logic [31:0] shadow_keys[ENTRIES];
  logic [31:0] shadow_values[ENTRIES];
  int          shadow_count;

  int          failures;
  int          ops_taken;
  int          results_seen;
  int          idle_cycles;

  table_op_t   next_op;
  bit          have_next;
  bit          offer_taken;
  int          gap_left;
  bit          tx_idle_on;

  bit          result_taken;
  int          stall_left;
  bit          rx_idle_on;

  logic [31:0] key_pool[24];
  logic [31:0] val_pool[8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t apply_table_op(cmd_t op, logic [31:0] k, logic [31:0] v);
    int      slot;
    bit      val_hit;
    status_t st;
    result_t r;
    slot    = -1;
    val_hit = 1'b0;
    for (int i = 0; i < shadow_count; i++) begin
      if (slot < 0 && shadow_keys[i] == k) slot = i;
      if (shadow_values[i] == v) val_hit = 1'b1;
    end
    case (op)
      CMD_INSERT: begin
        if (slot >= 0) begin
          st = ST_DUP;
        end else if (shadow_count >= ENTRIES) begin
          st = ST_FULL;
        end else begin
          shadow_keys[shadow_count]   = k;
          shadow_values[shadow_count] = v;
          shadow_count++;
          st = ST_OK;
        end
      end
      CMD_ERASE: begin
        if (slot >= 0) begin
          shadow_keys[slot]   = shadow_keys[shadow_count-1];
          shadow_values[slot] = shadow_values[shadow_count-1];
          shadow_count--;
          st = ST_OK;
        end else begin
          st = ST_MISS;
        end
      end
      CMD_KEY_Q: begin
        st = (slot >= 0) ? ST_OK : ST_MISS;
      end
      default: begin
        st = val_hit ? ST_OK : ST_MISS;
      end
    endcase
    r.status      = st;
    r.entry_count = COUNT_W'(shadow_count);
    return r;
  endfunction

  task automatic push_op(cmd_t op, logic [31:0] k, logic [31:0] v, bit drain = 1'b0);
    table_op_t t;
    t.op          = op;
    t.key         = k;
    t.value       = v;
    t.drain_first = drain;
    op_queue.push_back(t);
  endtask

  // input side: predict on every transfer
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      due_results.push_back(apply_table_op(cmd_t'(in_ch.cmd), in_ch.key, in_ch.value));
      ops_taken++;
      offer_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || offer_taken) begin
      offer_taken = 1'b0;
      if (!have_next && op_queue.size() != 0) begin
        next_op   = op_queue.pop_front();
        have_next = 1'b1;
        if (ops_taken % 50 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
        gap_left  = tx_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (!have_next || (next_op.drain_first && due_results.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.cmd   <= next_op.op;
        in_ch.key   <= next_op.key;
        in_ch.value <= next_op.value;
        in_ch.valid <= 1'b1;
        have_next   = 1'b0;
      end
    end
  end

  // output side: check each transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result with nothing expected: status %0d entry_count %0d",
               out_ch.status, out_ch.entry_count);
        failures++;
      end else begin
        result_t exp_r;
        exp_r = due_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
          failures++;
        end
        if (out_ch.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                 out_ch.entry_count);
          failures++;
        end
      end
      results_seen++;
      result_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        if (results_seen % 40 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
        stall_left = rx_idle_on ? $urandom_range(0, 12) : 0;
        if (results_seen == 300) stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("keyed_value_table regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int burst_len;
    int insert_pct;
    int r;
    cmd_t op;
    logic [31:0] k;
    logic [31:0] v;

    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_INSERT;
    in_ch.key     = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    rst           = 1'b1;
    failures      = 0;
    ops_taken     = 0;
    results_seen  = 0;
    idle_cycles   = 0;
    shadow_count  = 0;
    have_next     = 1'b0;
    offer_taken   = 1'b0;
    gap_left      = 0;
    tx_idle_on    = 1'b1;
    result_taken  = 1'b0;
    stall_left    = 0;
    rx_idle_on    = 1'b1;

    push_op(CMD_ERASE,   32'h0000_0005, 32'h0);
    push_op(CMD_KEY_Q,   32'h8000_0000, 32'h0);
    push_op(CMD_VALUE_Q, 32'h0,         32'h0);
    push_op(CMD_INSERT,  32'h8000_0000, 32'h7FFF_FFFF);
    push_op(CMD_ERASE,   32'h7FFF_FFFF, 32'h0);
    push_op(CMD_INSERT,  32'h7FFF_FFFF, 32'h8000_0000);
    push_op(CMD_INSERT,  32'h0,         32'hFFFF_FFFF);
    push_op(CMD_INSERT,  32'hFFFF_FFFF, 32'h0);
    push_op(CMD_INSERT,  32'h0,         32'h0000_0001);
    push_op(CMD_KEY_Q,   32'hFFFF_FFFF, 32'h0);
    push_op(CMD_KEY_Q,   32'h0000_0001, 32'h0);
    push_op(CMD_VALUE_Q, 32'h0,         32'h8000_0000);
    push_op(CMD_VALUE_Q, 32'h0,         32'h1234_5678);
    push_op(CMD_ERASE,   32'h7FFF_FFFF, 32'h0);
    push_op(CMD_KEY_Q,   32'hFFFF_FFFF, 32'h0);
    push_op(CMD_ERASE,   32'hFFFF_FFFF, 32'h0);
    push_op(CMD_ERASE,   32'h8000_0000, 32'h0);
    push_op(CMD_ERASE,   32'h0,         32'h0);
    push_op(CMD_ERASE,   32'h0,         32'h0);
    push_op(CMD_INSERT,  32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1);

    n = 0;
    while (n < 1030) begin
      if (n == 0 || $urandom_range(0, 2) == 0) begin
        foreach (key_pool[i]) key_pool[i] = $urandom();
        foreach (val_pool[i]) val_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        val_pool[0] = 32'hFFFF_FFFF;
      end
      burst_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 20;
        1:       insert_pct = 50;
        default: insert_pct = 75;
      endcase
      for (int j = 0; j < burst_len; j++) begin
        r = $urandom_range(0, 99);
        if (r < insert_pct)                         op = CMD_INSERT;
        else if (r < insert_pct + (100 - insert_pct) / 2) op = CMD_ERASE;
        else if (r % 2 == 0)                        op = CMD_KEY_Q;
        else                                        op = CMD_VALUE_Q;
        k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 23)];
        v = ($urandom_range(0, 4) == 0) ? $urandom() : val_pool[$urandom_range(0, 7)];
        push_op(op, k, v, (j == 0) && ($urandom_range(0, 3) == 0));
        n++;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || have_next || in_ch.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (failures == 0 && due_results.size() == 0) begin
      $display("keyed_value_table regression: pass");
    end else begin
      $display("keyed_value_table regression: fail");
    end
    $finish;
  end

endmodule

// ===== keyed_value_table.f =====
design/kvt_pkg.sv
design/kvt_in_if.sv
design/kvt_out_if.sv
design/kvt_ram.sv
design/kvt_ctrl.sv
design/keyed_value_table.sv
tb/sv/tb_keyed_value_table.sv
